@@ hw/rtl/assert_macros.svh @@
// assertion macros used by the checker file atk_chk
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ASSERT_NOW(lbl, clk, rst_n, ant, con, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ant) |-> (con)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(lbl, clk, rst_n, ant, con, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ant) |=> (con)) \
        else $error(msg);

`endif

@@ hw/rtl/atk_pkg.sv @@
// shared types, constants and helper functions for the atkin prime sieve
// no dependencies
`timescale 1ns / 1ps

package atk_pkg;

    localparam int IDX_W          = 13;
    localparam int VAL_W          = 16;
    localparam int TOT_W          = 13;
    localparam int CFG_W          = 16;
    localparam int CFG_MAX        = 2**CFG_W - 1;
    localparam int MIN_LIMIT      = 3;
    localparam int FIRST_SQF      = 5;
    localparam int DEF_MAX_LIMIT  = 65535;
    localparam int DEF_MAX_PRIMES = 8192;

    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_LATCH,
        CMD_SQRT_STEP,
        CMD_CLEAR_INIT,
        CMD_CLEAR_STEP,
        CMD_QUAD_INIT,
        CMD_TOG_RD_A,
        CMD_TOG_RD_B,
        CMD_TOG_RD_C,
        CMD_TOG_WR,
        CMD_QUAD_NEXT,
        CMD_SQF_INIT,
        CMD_SQF_RD,
        CMD_SQF_START,
        CMD_SQF_CLR,
        CMD_SQF_NEXT,
        CMD_PACK_INIT,
        CMD_PACK_STEP,
        CMD_LOOKUP,
        CMD_CAPTURE
    } t_cmd;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SQRT,
        ST_CLEAR,
        ST_QINIT,
        ST_QA,
        ST_QA_WR,
        ST_QB,
        ST_QB_WR,
        ST_QC,
        ST_QC_WR,
        ST_QNEXT,
        ST_SQF_CHK,
        ST_SQF_TEST,
        ST_SQF_CLR,
        ST_PACK,
        ST_PACK_END,
        ST_LOOK,
        ST_CAP,
        ST_RESP
    } t_state;

    typedef struct packed {
        logic sqrt_done;
        logic k_last;
        logic hit_a;
        logic hit_b;
        logic hit_c;
        logic quad_last;
        logic x_over;
        logic flag_set;
        logic k_over;
    } t_status;

    // square of a residue, mod 12
    function automatic logic [3:0] sq_mod12(input logic [3:0] m);
        logic [3:0] r;
        case (m)
            4'd1, 4'd5, 4'd7, 4'd11: r = 4'd1;
            4'd2, 4'd4, 4'd8, 4'd10: r = 4'd4;
            4'd3, 4'd9:              r = 4'd9;
            default:                 r = 4'd0;
        endcase
        return r;
    endfunction

    // reduce a small sum (below 72) mod 12
    function automatic logic [3:0] mod12_small(input logic [6:0] v);
        logic [6:0] r;
        r = v;
        for (int i = 0; i < 5; i++) begin
            if (r >= 7'd12) r = r - 7'd12;
        end
        return r[3:0];
    endfunction

    function automatic logic [3:0] inc12(input logic [3:0] m);
        return (m == 4'd11) ? 4'd0 : m + 4'd1;
    endfunction

endpackage

@@ hw/rtl/atk_ifs.sv @@
// handshake channels of the prime sieve: request, result and limit write
// depends on atk_pkg
`timescale 1ns / 1ps

interface atk_req_if;
    import atk_pkg::*;
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] prime_index;
    modport source (output valid, output prime_index, input ready);
    modport sink   (input valid, input prime_index, output ready);
endinterface

interface atk_rsp_if;
    import atk_pkg::*;
    logic             valid;
    logic             ready;
    logic [VAL_W-1:0] prime_value;
    logic [TOT_W-1:0] prime_total;
    logic             index_in_range;
    modport source (output valid, output prime_value, output prime_total,
                    output index_in_range, input ready);
    modport sink   (input valid, input prime_value, input prime_total,
                    input index_in_range, output ready);
endinterface

interface atk_cfg_if;
    import atk_pkg::*;
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] sieve_limit;
    modport source (output valid, output sieve_limit, input ready);
    modport sink   (input valid, input sieve_limit, output ready);
endinterface

@@ hw/rtl/atk_ram.sv @@
// generic simple dual-port ram, one write port, one registered read port
// no dependencies
`timescale 1ns / 1ps

module atk_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

@@ hw/rtl/atk_ctrl.sv @@
// sequencer of the sieve: walks the phases and drives the datapath commands
// depends on atk_pkg
`timescale 1ns / 1ps

module atk_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    input  logic             i_rsp_ready,
    input  logic             i_cfg_wr,
    input  atk_pkg::t_status i_status,
    output atk_pkg::t_cmd    o_cmd,
    output logic             o_req_ready,
    output logic             o_rsp_valid
);
    import atk_pkg::*;

    t_state r_state, n_state;
    logic   r_sieve_valid, n_sieve_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_sieve_valid <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_sieve_valid <= n_sieve_valid;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_sieve_valid = r_sieve_valid;
        o_cmd         = CMD_NONE;
        o_req_ready   = 1'b0;
        o_rsp_valid   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd   = CMD_LATCH;
                    n_state = r_sieve_valid ? ST_LOOK : ST_SQRT;
                end
            end
            ST_SQRT: begin
                if (i_status.sqrt_done) begin
                    o_cmd   = CMD_CLEAR_INIT;
                    n_state = ST_CLEAR;
                end else begin
                    o_cmd = CMD_SQRT_STEP;
                end
            end
            ST_CLEAR: begin
                o_cmd = CMD_CLEAR_STEP;
                if (i_status.k_last) n_state = ST_QINIT;
            end
            ST_QINIT: begin
                o_cmd   = CMD_QUAD_INIT;
                n_state = ST_QA;
            end
            ST_QA: begin
                if (i_status.hit_a) begin
                    o_cmd   = CMD_TOG_RD_A;
                    n_state = ST_QA_WR;
                end else begin
                    n_state = ST_QB;
                end
            end
            ST_QA_WR: begin
                o_cmd   = CMD_TOG_WR;
                n_state = ST_QB;
            end
            ST_QB: begin
                if (i_status.hit_b) begin
                    o_cmd   = CMD_TOG_RD_B;
                    n_state = ST_QB_WR;
                end else begin
                    n_state = ST_QC;
                end
            end
            ST_QB_WR: begin
                o_cmd   = CMD_TOG_WR;
                n_state = ST_QC;
            end
            ST_QC: begin
                if (i_status.hit_c) begin
                    o_cmd   = CMD_TOG_RD_C;
                    n_state = ST_QC_WR;
                end else begin
                    n_state = ST_QNEXT;
                end
            end
            ST_QC_WR: begin
                o_cmd   = CMD_TOG_WR;
                n_state = ST_QNEXT;
            end
            ST_QNEXT: begin
                if (i_status.quad_last) begin
                    o_cmd   = CMD_SQF_INIT;
                    n_state = ST_SQF_CHK;
                end else begin
                    o_cmd   = CMD_QUAD_NEXT;
                    n_state = ST_QA;
                end
            end
            ST_SQF_CHK: begin
                if (i_status.x_over) begin
                    o_cmd   = CMD_PACK_INIT;
                    n_state = ST_PACK;
                end else begin
                    o_cmd   = CMD_SQF_RD;
                    n_state = ST_SQF_TEST;
                end
            end
            ST_SQF_TEST: begin
                if (i_status.flag_set) begin
                    o_cmd   = CMD_SQF_START;
                    n_state = ST_SQF_CLR;
                end else begin
                    o_cmd   = CMD_SQF_NEXT;
                    n_state = ST_SQF_CHK;
                end
            end
            ST_SQF_CLR: begin
                if (i_status.k_over) begin
                    o_cmd   = CMD_SQF_NEXT;
                    n_state = ST_SQF_CHK;
                end else begin
                    o_cmd = CMD_SQF_CLR;
                end
            end
            ST_PACK: begin
                o_cmd = CMD_PACK_STEP;
                if (i_status.k_last) n_state = ST_PACK_END;
            end
            ST_PACK_END: begin
                // last flag read drains here
                n_sieve_valid = 1'b1;
                n_state       = ST_LOOK;
            end
            ST_LOOK: begin
                o_cmd   = CMD_LOOKUP;
                n_state = ST_CAP;
            end
            ST_CAP: begin
                o_cmd   = CMD_CAPTURE;
                n_state = ST_RESP;
            end
            ST_RESP: begin
                o_rsp_valid = 1'b1;
                if (i_rsp_ready) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
        if (i_cfg_wr) n_sieve_valid = 1'b0;
    end

endmodule

@@ hw/rtl/atk_dp.sv @@
// sieve datapath: limit register, loop counters, flag store and prime list
// depends on atk_pkg and atk_ram
`timescale 1ns / 1ps

module atk_dp #(
    parameter int MAX_LIMIT  = atk_pkg::DEF_MAX_LIMIT,
    parameter int MAX_PRIMES = atk_pkg::DEF_MAX_PRIMES
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr,
    input  logic [atk_pkg::CFG_W-1:0]  i_cfg_data,
    input  logic [atk_pkg::IDX_W-1:0]  i_index,
    input  atk_pkg::t_cmd              i_cmd,
    output atk_pkg::t_status           o_status,
    output logic [atk_pkg::VAL_W-1:0]  o_value,
    output logic [atk_pkg::TOT_W-1:0]  o_total,
    output logic                       o_in_range
);
    import atk_pkg::*;

    localparam int LIMIT_CAP = (MAX_LIMIT < CFG_MAX) ? MAX_LIMIT : CFG_MAX;
    localparam int LIM_W     = $clog2(LIMIT_CAP + 1);
    localparam int K_W       = LIM_W + 1;
    localparam int S_W       = (LIM_W + 1) / 2 + 1;
    localparam int A_W       = LIM_W + 4;
    localparam int PA_W      = $clog2(MAX_PRIMES);
    localparam int CNT_W     = $clog2(MAX_PRIMES + 1);
    localparam int CMP_W     = (CNT_W > IDX_W) ? CNT_W : IDX_W;

    logic [LIM_W-1:0] r_limit;
    logic [CNT_W-1:0] r_cnt;
    logic             r_pv;
    logic [IDX_W-1:0] r_idx;
    logic [S_W-1:0]   r_s, r_x, r_y;
    logic [3:0]       r_xm, r_ym;
    logic [A_W-1:0]   r_xx, r_yy;
    logic [K_W-1:0]   r_k, r_sq;
    logic [LIM_W-1:0] r_taddr, r_pk;
    logic [VAL_W-1:0] r_value;
    logic [TOT_W-1:0] r_total;
    logic             r_ok;

    logic [S_W-1:0]   s_plus;
    logic [2*S_W-1:0] sq_next, x_sq;
    logic [A_W-1:0]   val_a, val_b, val_c, lim_a;
    logic [3:0]       xxm, yym, am, bm, cm;
    logic [CMP_W-1:0] idx_ext, cnt_ext;
    logic             in_range, list_full;

    logic             f_we, f_wdata, f_rdata;
    logic [LIM_W-1:0] f_waddr, f_raddr;
    logic             l_we;
    logic [LIM_W-1:0] l_rdata;

    assign s_plus  = r_s + 1'b1;
    assign sq_next = (2*S_W)'(s_plus) * (2*S_W)'(s_plus);
    assign x_sq    = (2*S_W)'(r_x) * (2*S_W)'(r_x);

    assign val_a = (r_xx << 2) + r_yy;
    assign val_b = (r_xx << 1) + r_xx + r_yy;
    assign val_c = (r_xx << 1) + r_xx - r_yy;
    assign lim_a = A_W'(r_limit);

    // residues follow x and y so no wide mod is needed
    assign xxm = sq_mod12(r_xm);
    assign yym = sq_mod12(r_ym);
    assign am  = mod12_small(7'({xxm, 2'b00}) + 7'(yym));
    assign bm  = mod12_small(7'(xxm) + 7'({xxm, 1'b0}) + 7'(yym));
    assign cm  = mod12_small(7'(xxm) + 7'({xxm, 1'b0}) + 7'd12 - 7'(yym));

    assign idx_ext   = CMP_W'(r_idx);
    assign cnt_ext   = CMP_W'(r_cnt);
    assign in_range  = idx_ext < cnt_ext;
    assign list_full = r_cnt == CNT_W'(MAX_PRIMES);

    always_comb begin
        o_status.sqrt_done = sq_next > (2*S_W)'(r_limit);
        o_status.k_last    = r_k == K_W'(r_limit);
        o_status.hit_a     = (val_a <= lim_a) && (am == 4'd1 || am == 4'd5);
        o_status.hit_b     = (val_b <= lim_a) && (bm == 4'd7);
        o_status.hit_c     = (r_x > r_y) && (val_c <= lim_a) && (cm == 4'd11);
        o_status.quad_last = (r_x == r_s) && (r_y == r_s);
        o_status.x_over    = r_x > r_s;
        o_status.flag_set  = f_rdata;
        o_status.k_over    = r_k > K_W'(r_limit);
    end

    // flag store port steering
    always_comb begin
        f_we    = 1'b0;
        f_waddr = r_k[LIM_W-1:0];
        f_wdata = 1'b0;
        f_raddr = r_k[LIM_W-1:0];
        case (i_cmd)
            CMD_CLEAR_STEP: begin
                f_we    = 1'b1;
                f_wdata = (r_k == K_W'(2)) || (r_k == K_W'(3));
            end
            CMD_TOG_RD_A: f_raddr = val_a[LIM_W-1:0];
            CMD_TOG_RD_B: f_raddr = val_b[LIM_W-1:0];
            CMD_TOG_RD_C: f_raddr = val_c[LIM_W-1:0];
            CMD_TOG_WR: begin
                f_we    = 1'b1;
                f_waddr = r_taddr;
                f_wdata = ~f_rdata;
            end
            CMD_SQF_RD:  f_raddr = LIM_W'(r_x);
            CMD_SQF_CLR: f_we = 1'b1;
            default: ;
        endcase
    end

    assign l_we = r_pv && f_rdata && !list_full;

    atk_ram #(
        .WIDTH (1),
        .DEPTH (LIMIT_CAP + 1)
    ) u_flags (
        .i_clk   (i_clk),
        .i_we    (f_we),
        .i_waddr (f_waddr),
        .i_wdata (f_wdata),
        .i_raddr (f_raddr),
        .o_rdata (f_rdata)
    );

    atk_ram #(
        .WIDTH (LIM_W),
        .DEPTH (MAX_PRIMES)
    ) u_list (
        .i_clk   (i_clk),
        .i_we    (l_we),
        .i_waddr (r_cnt[PA_W-1:0]),
        .i_wdata (r_pk),
        .i_raddr (idx_ext[PA_W-1:0]),
        .o_rdata (l_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIM_W'(LIMIT_CAP);
            r_cnt   <= '0;
            r_pv    <= 1'b0;
        end else begin
            if (i_cfg_wr) begin
                if (i_cfg_data < CFG_W'(MIN_LIMIT)) begin
                    r_limit <= LIM_W'(MIN_LIMIT);
                end else if (i_cfg_data > CFG_W'(LIMIT_CAP)) begin
                    r_limit <= LIM_W'(LIMIT_CAP);
                end else begin
                    r_limit <= LIM_W'(i_cfg_data);
                end
            end
            if (i_cmd == CMD_PACK_INIT) begin
                r_cnt <= '0;
            end else if (l_we) begin
                r_cnt <= r_cnt + 1'b1;
            end
            r_pv <= (i_cmd == CMD_PACK_STEP);
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd)
            CMD_LATCH: begin
                r_idx <= i_index;
                r_s   <= '0;
            end
            CMD_SQRT_STEP:  r_s <= s_plus;
            CMD_CLEAR_INIT: r_k <= '0;
            CMD_CLEAR_STEP: r_k <= r_k + 1'b1;
            CMD_QUAD_INIT: begin
                r_x  <= S_W'(1);
                r_y  <= S_W'(1);
                r_xm <= 4'd1;
                r_ym <= 4'd1;
                r_xx <= A_W'(1);
                r_yy <= A_W'(1);
            end
            CMD_TOG_RD_A: r_taddr <= val_a[LIM_W-1:0];
            CMD_TOG_RD_B: r_taddr <= val_b[LIM_W-1:0];
            CMD_TOG_RD_C: r_taddr <= val_c[LIM_W-1:0];
            CMD_QUAD_NEXT: begin
                if (r_y == r_s) begin
                    r_y  <= S_W'(1);
                    r_ym <= 4'd1;
                    r_yy <= A_W'(1);
                    r_x  <= r_x + 1'b1;
                    r_xm <= inc12(r_xm);
                    r_xx <= r_xx + (A_W'(r_x) << 1) + 1'b1;
                end else begin
                    r_y  <= r_y + 1'b1;
                    r_ym <= inc12(r_ym);
                    r_yy <= r_yy + (A_W'(r_y) << 1) + 1'b1;
                end
            end
            CMD_SQF_INIT: r_x <= S_W'(FIRST_SQF);
            CMD_SQF_START: begin
                r_sq <= K_W'(x_sq);
                r_k  <= K_W'(x_sq);
            end
            CMD_SQF_CLR:   r_k <= r_k + r_sq;
            CMD_SQF_NEXT:  r_x <= r_x + 1'b1;
            CMD_PACK_INIT: r_k <= K_W'(1);
            CMD_PACK_STEP: begin
                r_k  <= r_k + 1'b1;
                r_pk <= r_k[LIM_W-1:0];
            end
            CMD_CAPTURE: begin
                r_value <= in_range ? VAL_W'(l_rdata) : '0;
                r_total <= TOT_W'(r_cnt);
                r_ok    <= in_range;
            end
            default: ;
        endcase
    end

    assign o_value    = r_value;
    assign o_total    = r_total;
    assign o_in_range = r_ok;

endmodule

@@ hw/rtl/atkin_prime_sieve_core.sv @@
// top level of the atkin prime sieve: controller, datapath and channels
// depends on atk_pkg, atk_ifs, atk_ctrl and atk_dp
`timescale 1ns / 1ps

// Prime lookup by index over a sieve of Atkin. The first request after reset
// or after a limit write runs the full sieve on one simple dual-port flag
// memory (one write port, one registered read port): it finds the root of the
// limit, clears the flags, toggles flags in the quadratic pass over (x,y)
// pairs, strikes the multiples of each prime square and then packs the prime
// list. With the list built, a request goes through latch, list read and
// capture before its result word is offered, and the next word is taken once
// the result word has been delivered. The limit port is always ready.
module atkin_prime_sieve_core #(
    parameter int MAX_LIMIT  = atk_pkg::DEF_MAX_LIMIT,
    parameter int MAX_PRIMES = atk_pkg::DEF_MAX_PRIMES
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    atk_req_if.sink   i_req,
    atk_rsp_if.source o_rsp,
    atk_cfg_if.sink   i_cfg
);
    import atk_pkg::*;

    t_cmd    cmd;
    t_status status;
    logic    cfg_wr;

    assign i_cfg.ready = 1'b1;
    assign cfg_wr      = i_cfg.valid & i_cfg.ready;

    atk_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_rsp_ready (o_rsp.ready),
        .i_cfg_wr    (cfg_wr),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_req_ready (i_req.ready),
        .o_rsp_valid (o_rsp.valid)
    );

    atk_dp #(
        .MAX_LIMIT  (MAX_LIMIT),
        .MAX_PRIMES (MAX_PRIMES)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_wr   (cfg_wr),
        .i_cfg_data (i_cfg.sieve_limit),
        .i_index    (i_req.prime_index),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_value    (o_rsp.prime_value),
        .o_total    (o_rsp.prime_total),
        .o_in_range (o_rsp.index_in_range)
    );

endmodule

@@ hw/rtl/atk_chk.sv @@
// port-level checks of the prime sieve, bound to the top level
// depends on assert_macros.svh and atk_pkg
`timescale 1ns / 1ps
`include "assert_macros.svh"

module atk_chk (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_req_valid,
    input logic                       i_req_ready,
    input logic                       i_rsp_valid,
    input logic                       i_rsp_ready,
    input logic [atk_pkg::VAL_W-1:0]  i_value,
    input logic [atk_pkg::TOT_W-1:0]  i_total,
    input logic                       i_ok
);
    import atk_pkg::*;

    logic req_acc;

    assign req_acc = i_req_valid && i_req_ready;

    // result word holds while stalled
    `ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready, i_rsp_valid && $stable(i_value) && $stable(i_total) && $stable(i_ok), "stalled result changed")
    // primes are never zero, so the flag matches a nonzero value
    `ASSERT_NOW(a_ok_value, i_clk, i_rst_n, i_rsp_valid, i_ok == (i_value != '0), "range flag and value disagree")
    // one request in flight at a time
    `ASSERT_NEXT(a_one_req, i_clk, i_rst_n, req_acc, !i_req_ready, "request taken while one pending")
    `ASSERT_NOW(a_no_overlap, i_clk, i_rst_n, i_rsp_valid, !i_req_ready, "request open during result")

endmodule

bind atkin_prime_sieve_core atk_chk u_atk_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_value     (o_rsp.prime_value),
    .i_total     (o_rsp.prime_total),
    .i_ok        (o_rsp.index_in_range)
);

@@ test/testbench.sv @@
// self-checking bench for atkin_prime_sieve_core: index requests against a local sieve
// depends on atk_pkg, atk_ifs and the core rtl
`timescale 1ns / 1ps

module testbench;
    import atk_pkg::*;

    typedef struct {
        logic [VAL_W-1:0] prime_value;
        logic [TOT_W-1:0] prime_total;
        logic             index_in_range;
    } t_lookup;

    class prime_scoreboard;
        logic [CFG_W-1:0] limit;
        bit               list_built;
        logic [VAL_W-1:0] primes[DEF_MAX_PRIMES];
        int               prime_count;
        bit               flags[DEF_MAX_LIMIT+1];
        t_lookup          pending_q[$];
        int               errors;

        function void reset_state();
            limit       = CFG_W'(DEF_MAX_LIMIT);
            list_built  = 0;
            prime_count = 0;
            errors      = 0;
        endfunction

        function void note_limit(logic [CFG_W-1:0] v);
            if (v < MIN_LIMIT) limit = CFG_W'(MIN_LIMIT);
            else if (v > DEF_MAX_LIMIT) limit = CFG_W'(DEF_MAX_LIMIT);
            else limit = v;
            list_built = 0;
        endfunction

        function void build_list();
            int n;
            int root;
            longint a;
            longint b;
            longint c;
            n = limit;
            root = 0;
            while ((root + 1) * (root + 1) <= n) root++;
            foreach (flags[k]) flags[k] = 0;
            flags[2] = 1;
            flags[3] = 1;
            for (int x = 1; x <= root; x++) begin
                for (int y = 1; y <= root; y++) begin
                    a = 4 * x * x + y * y;
                    b = 3 * x * x + y * y;
                    if (a <= n && (a % 12 == 1 || a % 12 == 5)) flags[a] = !flags[a];
                    if (b <= n && b % 12 == 7) flags[b] = !flags[b];
                    if (x > y) begin
                        c = 3 * x * x - y * y;
                        if (c <= n && c % 12 == 11) flags[c] = !flags[c];
                    end
                end
            end
            // strike multiples of prime squares
            for (int x = FIRST_SQF; x <= root; x++) begin
                if (flags[x]) begin
                    for (int k = x * x; k <= n; k += x * x) flags[k] = 0;
                end
            end
            prime_count = 0;
            for (int k = 1; k <= n; k++) begin
                if (flags[k] && prime_count < DEF_MAX_PRIMES) begin
                    primes[prime_count] = VAL_W'(k);
                    prime_count++;
                end
            end
            list_built = 1;
        endfunction

        function void note_request(logic [IDX_W-1:0] idx);
            t_lookup e;
            if (!list_built) build_list();
            e.prime_total = TOT_W'(prime_count);
            e.index_in_range = (idx < prime_count);
            e.prime_value = e.index_in_range ? primes[idx] : '0;
            pending_q.push_back(e);
        endfunction

        function void check_word(logic [VAL_W-1:0] v, logic [TOT_W-1:0] t, logic r);
            t_lookup e;
            if (pending_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result word value=%0d total=%0d", v, t);
                return;
            end
            e = pending_q.pop_front();
            if (v !== e.prime_value || t !== e.prime_total || r !== e.index_in_range) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: exp value=%0d total=%0d in=%0d, ",
                             e.prime_value, e.prime_total, e.index_in_range,
                             "got value=%0d total=%0d in=%0d", v, t, r);
            end
        endfunction

        function int outstanding();
            return pending_q.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    bit   quiet;

    atk_req_if req_if();
    atk_rsp_if rsp_if();
    atk_cfg_if cfg_if();

    prime_scoreboard sb;

    atkin_prime_sieve_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .i_cfg   (cfg_if)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    initial begin
        #50_000_000;
        $display("FAIL atkin_prime_sieve_core");
        $finish;
    end

    // result side: ready in random bursts with gaps, always ready once quiet
    initial begin
        rsp_if.ready = 1'b0;
        forever begin
            if (quiet || $urandom_range(0, 3) != 0) begin
                rsp_if.ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(negedge i_clk);
            end else begin
                rsp_if.ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(negedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready)
            sb.check_word(rsp_if.prime_value, rsp_if.prime_total, rsp_if.index_in_range);
    end

    task automatic send_index(input logic [IDX_W-1:0] idx);
        @(negedge i_clk);
        req_if.valid       <= 1'b1;
        req_if.prime_index <= idx;
        do @(posedge i_clk); while (!req_if.ready);
        sb.note_request(idx);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            @(negedge i_clk);
            req_if.valid <= 1'b0;
            repeat ($urandom_range(0, 10)) @(negedge i_clk);
        end
    endtask

    task automatic write_limit(input logic [CFG_W-1:0] v);
        @(negedge i_clk);
        req_if.valid    <= 1'b0;
        cfg_if.valid       <= 1'b1;
        cfg_if.sieve_limit <= v;
        do @(posedge i_clk); while (!cfg_if.ready);
        sb.note_limit(v);
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic drain();
        @(negedge i_clk);
        req_if.valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // mostly indices within the prime list or just past it, some across the whole field
    task automatic random_indices(input int count);
        int top;
        for (int i = 0; i < count; i++) begin
            top = (sb.prime_count + 3 > 8191) ? 8191 : sb.prime_count + 3;
            if ($urandom_range(0, 3) == 0) send_index(IDX_W'($urandom_range(0, 8191)));
            else send_index(IDX_W'($urandom_range(0, top)));
        end
    endtask

    int limits[] = '{0, 1, 2, 3, 4, 5, 24, 25, 49, 121, 1000, 4096, 12345, 30000};

    initial begin
        sb = new();
        sb.reset_state();
        quiet = 0;
        i_rst_n = 1'b0;
        req_if.valid = 1'b0;
        req_if.prime_index = '0;
        cfg_if.valid = 1'b0;
        cfg_if.sieve_limit = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset limit: ends of the list and single index bits
        send_index(13'd0);
        send_index(13'd1);
        send_index(13'd2);
        send_index(13'd6540);
        send_index(13'd6541);
        send_index(13'd6542);
        send_index(13'd8191);
        for (int b = 0; b < IDX_W; b++) send_index(13'd1 << b);
        random_indices(150);
        drain();
        random_indices(150);
        drain();

        // largest write value, immediately replaced
        write_limit(16'hFFFF);
        foreach (limits[p]) begin
            if (p == limits.size() - 1) quiet = 1;
            write_limit(CFG_W'(limits[p]));
            send_index(13'd0);
            send_index(13'd1);
            send_index(13'd8191);
            random_indices(25);
            drain();
        end

        if (sb.errors == 0) begin
            $display("PASS atkin_prime_sieve_core");
        end else begin
            $display("FAIL atkin_prime_sieve_core");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/atk_pkg.sv
hw/rtl/atk_ifs.sv
hw/rtl/atk_ram.sv
hw/rtl/atk_ctrl.sv
hw/rtl/atk_dp.sv
hw/rtl/atkin_prime_sieve_core.sv
hw/rtl/atk_chk.sv
test/testbench.sv
